>>> hw/rtl/gpsc_pkg.sv
// ----------------------------------------------------------------------------
// gpsc_pkg - shared definitions for the power-of-two square cover block
// Field widths of the request and result ports and the register indexes of
// the configuration port.
// ----------------------------------------------------------------------------
package gpsc_pkg;

  // Fixed widths of the external fields.
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int TILE_XY_W  = 6;
  localparam int TILE_LS_W  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_EDGE_SMALL  = 2'd2
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] GRID_DIM_RST = 7'd64;

endpackage

>>> hw/rtl/gpsc_ram.sv
// ----------------------------------------------------------------------------
// gpsc_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gpsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> hw/rtl/greedy_pow2_square_cover.sv
// ----------------------------------------------------------------------------
// greedy_pow2_square_cover - greedy power-of-two square tiling of a grid
// Hands out one square tile per request, always placed at the first uncovered
// cell in row-major order and grown while it stays clear, inside the grid and cap.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Transfer
//  -------   -------------------------------------   ---------------------------
//  request   start, busy, in_restart                 start high while busy low
//  result    out_strobe, out_tile_*, out_last_tile   out_strobe high, one cycle
//  config    cfg_we, cfg_index, cfg_wdata            cfg_we high, no wait
//
// A request that has a free cell keeps the block busy while it reads rows to
// find the first free cell, works out the cap in edge mode, tests each
// candidate side with a sweep of its rows until one is too large or not
// clear, and marks the rows of the chosen square; the result is registered
// as the block returns to idle. The single read port of the coverage row
// memory serves all of these sweeps, one row per cycle. A request that finds
// the cover already complete gives its result in the following cycle without
// going busy.
// Reset is synchronous and needs no clearing pass: every memory row carries a
// valid flag, and a row without one reads as uncovered. A restart clears all
// flags together. The receiver cannot stall, so a result is simply presented
// for one cycle.
//
module greedy_pow2_square_cover #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_LOG_SIDE = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_restart,
  // Result channel.
  output logic                              out_strobe,
  output logic [gpsc_pkg::TILE_XY_W-1:0]    out_tile_x,
  output logic [gpsc_pkg::TILE_XY_W-1:0]    out_tile_y,
  output logic [gpsc_pkg::TILE_LS_W-1:0]    out_tile_log_side,
  output logic                              out_tile_valid,
  output logic                              out_last_tile,
  // Configuration port.
  input  logic                              cfg_we,
  input  logic [gpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import gpsc_pkg::*;

  // Column index, row index, dimension, cell count and exponent widths.
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WL  = $clog2(MAX_WIDTH + 1);
  localparam int HL  = $clog2(MAX_HEIGHT + 1);
  localparam int CL  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KW  = $clog2(MAX_LOG_SIDE + 1);
  // Wide enough for any coordinate plus any side.
  localparam int DW  = $clog2(MAX_WIDTH + MAX_HEIGHT + (1 << MAX_LOG_SIDE)) + 1;
  localparam int KFW = $clog2(DW);

  // The sequencer. Scanning, growth checking and marking all sweep rows of
  // the memory through the same read pipeline.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCAN  = 10'b00_0000_0010,
    S_CAP1  = 10'b00_0000_0100,
    S_CAP2  = 10'b00_0000_1000,
    S_CAP3  = 10'b00_0001_0000,
    S_CAND  = 10'b00_0010_0000,
    S_GROW  = 10'b00_0100_0000,
    S_MPREP = 10'b00_1000_0000,
    S_MARK  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_w_r, cfg_h_r;
  logic                  cfg_edge_r;

  // Grid geometry latched at restart.
  logic [WL-1:0]        act_w_r, act_w_nxt;
  logic [HL-1:0]        act_h_r, act_h_nxt;
  logic                 act_edge_r, act_edge_nxt;
  logic [MAX_WIDTH-1:0] wmask_r, wmask_nxt;

  // Cover progress.
  logic [CL-1:0] cells_left_r, cells_left_nxt;
  logic [YW-1:0] scan_row_r, scan_row_nxt;

  // Current tile.
  logic [XW-1:0]        x0_r, x0_nxt;
  logic [YW-1:0]        y0_r, y0_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [KW-1:0]        cap_r, cap_nxt;
  logic [KFW-1:0]       kf_r, kf_nxt;
  logic [DW-1:0]        rem_w_r, rem_w_nxt;
  logic [DW-1:0]        rem_h_r, rem_h_nxt;
  logic [MAX_WIDTH-1:0] mask_r, mask_nxt;

  // Row sweep pipeline: the check side takes each row the cycle after its issue.
  logic [YW-1:0] iss_row_r, iss_row_nxt;
  logic [HL-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [YW-1:0] chk_row_r, chk_row_nxt;
  logic [HL-1:0] chk_cnt_r, chk_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic          rd_vld_r;

  // Per-row valid flags; a row that is not valid reads as all uncovered.
  logic [MAX_HEIGHT-1:0] row_vld_r;
  logic                  vld_set, vld_clr_all;

  // Memory port.
  logic                 ram_re, ram_we;
  logic [MAX_WIDTH-1:0] ram_rdata, row_eff, ram_wdata;

  // Result registers.
  logic                 out_strobe_r, out_strobe_nxt;
  logic [TILE_XY_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [TILE_LS_W-1:0] out_ls_r, out_ls_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;

  // Working values of the sequencer.
  logic [WL-1:0]        sat_w;
  logic [HL-1:0]        sat_h;
  logic [CL-1:0]        cl_eff, sq_cells;
  logic [YW-1:0]        scan_base;
  logic [HL-1:0]        h_eff;
  logic [MAX_WIDTH-1:0] scan_bits;
  logic [DW-1:0]        side_c, kp1, min_rem, d_min, side_f;
  logic [KFW-1:0]       cap_v;
  logic                 sweeping;

  // Bits x0 .. x0 + 2^lg - 1 of a row.
  function automatic logic [MAX_WIDTH-1:0] sq_mask(input logic [DW-1:0] x0,
                                                   input logic [DW-1:0] lg);
    logic [MAX_WIDTH-1:0] m;
    logic [DW-1:0]        hi;
    m  = '0;
    hi = x0 + (DW'(1) << lg);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m[i] = (DW'(i) >= x0) && (DW'(i) < hi);
    end
    return m;
  endfunction

  // Lowest clear bit of a row that is known to have one.
  function automatic logic [XW-1:0] first_zero(input logic [MAX_WIDTH-1:0] v);
    logic [XW-1:0] idx;
    idx = '0;
    for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = XW'(i);
      end
    end
    return idx;
  endfunction

  // Position of the highest set bit.
  function automatic logic [KFW-1:0] high_bit(input logic [DW-1:0] v);
    logic [KFW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DW; i++) begin
      if (v[i]) begin
        idx = KFW'(i);
      end
    end
    return idx;
  endfunction

  gpsc_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_row_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_row_r),
    .rdata (ram_rdata)
  );

  // Size registers saturate to the largest grid the map can hold.
  assign sat_w = (DW'(cfg_w_r) > DW'(MAX_WIDTH))  ? WL'(MAX_WIDTH)  : WL'(cfg_w_r);
  assign sat_h = (DW'(cfg_h_r) > DW'(MAX_HEIGHT)) ? HL'(MAX_HEIGHT) : HL'(cfg_h_r);

  assign row_eff   = rd_vld_r ? ram_rdata : '0;
  assign ram_wdata = row_eff | mask_r;
  assign sweeping  = (state_r == S_SCAN) || (state_r == S_GROW) || (state_r == S_MARK);

  always_comb begin
    state_nxt      = state_r;
    act_w_nxt      = act_w_r;
    act_h_nxt      = act_h_r;
    act_edge_nxt   = act_edge_r;
    wmask_nxt      = wmask_r;
    cells_left_nxt = cells_left_r;
    scan_row_nxt   = scan_row_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    k_nxt          = k_r;
    cap_nxt        = cap_r;
    kf_nxt         = kf_r;
    rem_w_nxt      = rem_w_r;
    rem_h_nxt      = rem_h_r;
    mask_nxt       = mask_r;
    iss_row_nxt    = iss_row_r;
    iss_cnt_nxt    = iss_cnt_r;
    chk_row_nxt    = chk_row_r;
    chk_cnt_nxt    = chk_cnt_r;
    pend_nxt       = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    vld_set        = 1'b0;
    vld_clr_all    = 1'b0;
    out_strobe_nxt = 1'b0;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_ls_nxt     = out_ls_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    cl_eff         = cells_left_r;
    scan_base      = scan_row_r;
    h_eff          = act_h_r;
    scan_bits      = row_eff | ~wmask_r;
    side_c         = '0;
    kp1            = DW'(k_r) + DW'(1);
    min_rem        = (rem_w_r < rem_h_r) ? rem_w_r : rem_h_r;
    side_f         = DW'(1) << kf_r;
    d_min          = '0;
    cap_v          = '0;
    sq_cells       = CL'(1) << ((KW + 1)'(k_r) << 1);

    // Read issue side of a row sweep: one row per cycle until the count runs out.
    if (sweeping && (iss_cnt_r != '0)) begin
      ram_re      = 1'b1;
      iss_row_nxt = iss_row_r + YW'(1);
      iss_cnt_nxt = iss_cnt_r - HL'(1);
      pend_nxt    = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_restart) begin
            vld_clr_all  = 1'b1;
            act_w_nxt    = sat_w;
            act_h_nxt    = sat_h;
            act_edge_nxt = cfg_edge_r;
            for (int i = 0; i < MAX_WIDTH; i++) begin
              wmask_nxt[i] = (DW'(i) < DW'(sat_w));
            end
            cl_eff    = CL'(CL'(sat_w) * CL'(sat_h));
            scan_base = '0;
            h_eff     = sat_h;
          end
          if ((cl_eff == '0) || (HL'(scan_base) >= h_eff)) begin
            // Cover already complete: an invalid tile with zero fields.
            cells_left_nxt = '0;
            out_strobe_nxt = 1'b1;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_ls_nxt     = '0;
            out_valid_nxt  = 1'b0;
            out_last_nxt   = 1'b0;
          end else begin
            cells_left_nxt = cl_eff;
            scan_row_nxt   = scan_base;
            iss_row_nxt    = scan_base;
            chk_row_nxt    = scan_base;
            iss_cnt_nxt    = h_eff - HL'(scan_base);
            chk_cnt_nxt    = h_eff - HL'(scan_base);
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (pend_r) begin
          if (~scan_bits != '0) begin
            x0_nxt       = first_zero(scan_bits);
            y0_nxt       = chk_row_r;
            scan_row_nxt = chk_row_r;
            k_nxt        = '0;
            if (act_edge_r) begin
              state_nxt = S_CAP1;
            end else begin
              cap_nxt   = KW'(MAX_LOG_SIDE);
              state_nxt = S_CAND;
            end
          end else if (chk_cnt_r == HL'(1)) begin
            // Map and count disagree: close the cover with an invalid tile.
            cells_left_nxt = '0;
            out_strobe_nxt = 1'b1;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_ls_nxt     = '0;
            out_valid_nxt  = 1'b0;
            out_last_nxt   = 1'b0;
            state_nxt      = S_IDLE;
          end else begin
            chk_row_nxt = chk_row_r + YW'(1);
            chk_cnt_nxt = chk_cnt_r - HL'(1);
          end
        end
      end

      S_CAP1: begin
        rem_w_nxt = DW'(act_w_r) - DW'(x0_r);
        rem_h_nxt = DW'(act_h_r) - DW'(y0_r);
        state_nxt = S_CAP2;
      end

      S_CAP2: begin
        kf_nxt    = high_bit(min_rem);
        state_nxt = S_CAP3;
      end

      S_CAP3: begin
        d_min = (DW'(x0_r) < DW'(y0_r)) ? DW'(x0_r) : DW'(y0_r);
        if ((rem_w_r - side_f) < d_min) begin
          d_min = rem_w_r - side_f;
        end
        if ((rem_h_r - side_f) < d_min) begin
          d_min = rem_h_r - side_f;
        end
        if (d_min == '0) begin
          cap_v = '0;
        end else if (d_min == DW'(1)) begin
          cap_v = (kf_r == '0) ? '0 : KFW'(1);
        end else begin
          cap_v = kf_r;
        end
        cap_nxt   = (DW'(cap_v) > DW'(MAX_LOG_SIDE)) ? KW'(MAX_LOG_SIDE) : KW'(cap_v);
        state_nxt = S_CAND;
      end

      S_CAND: begin
        side_c = DW'(1) << kp1;
        if ((kp1 > DW'(cap_r)) || (DW'(x0_r) + side_c > DW'(act_w_r)) ||
            (DW'(y0_r) + side_c > DW'(act_h_r))) begin
          state_nxt = S_MPREP;
        end else begin
          mask_nxt    = sq_mask(DW'(x0_r), kp1);
          iss_row_nxt = y0_r;
          chk_row_nxt = y0_r;
          iss_cnt_nxt = HL'(side_c);
          chk_cnt_nxt = HL'(side_c);
          state_nxt   = S_GROW;
        end
      end

      S_GROW: begin
        if (pend_r) begin
          if ((row_eff & mask_r) != '0) begin
            state_nxt = S_MPREP;
          end else if (chk_cnt_r == HL'(1)) begin
            k_nxt     = k_r + KW'(1);
            state_nxt = S_CAND;
          end else begin
            chk_row_nxt = chk_row_r + YW'(1);
            chk_cnt_nxt = chk_cnt_r - HL'(1);
          end
        end
      end

      S_MPREP: begin
        side_c         = DW'(1) << k_r;
        mask_nxt       = sq_mask(DW'(x0_r), DW'(k_r));
        iss_row_nxt    = y0_r;
        chk_row_nxt    = y0_r;
        iss_cnt_nxt    = HL'(side_c);
        chk_cnt_nxt    = HL'(side_c);
        // Every cell of the chosen square was free, so all of them count.
        cells_left_nxt = (cells_left_r >= sq_cells) ? (cells_left_r - sq_cells) : '0;
        state_nxt      = S_MARK;
      end

      S_MARK: begin
        if (pend_r) begin
          ram_we  = 1'b1;
          vld_set = 1'b1;
          if (chk_cnt_r == HL'(1)) begin
            state_nxt = S_DONE;
          end else begin
            chk_row_nxt = chk_row_r + YW'(1);
            chk_cnt_nxt = chk_cnt_r - HL'(1);
          end
        end
      end

      S_DONE: begin
        out_strobe_nxt = 1'b1;
        out_x_nxt      = TILE_XY_W'(x0_r);
        out_y_nxt      = TILE_XY_W'(y0_r);
        out_ls_nxt     = TILE_LS_W'(k_r);
        out_valid_nxt  = 1'b1;
        out_last_nxt   = (cells_left_r == '0);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_w_r      <= GRID_DIM_RST;
      cfg_h_r      <= GRID_DIM_RST;
      cfg_edge_r   <= 1'b0;
      act_w_r      <= '0;
      act_h_r      <= '0;
      act_edge_r   <= 1'b0;
      cells_left_r <= '0;
      scan_row_r   <= '0;
      row_vld_r    <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      act_w_r      <= act_w_nxt;
      act_h_r      <= act_h_nxt;
      act_edge_r   <= act_edge_nxt;
      cells_left_r <= cells_left_nxt;
      scan_row_r   <= scan_row_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (vld_clr_all) begin
        row_vld_r <= '0;
      end else if (vld_set) begin
        row_vld_r[chk_row_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  cfg_w_r    <= cfg_wdata;
          CFG_GRID_HEIGHT: cfg_h_r    <= cfg_wdata;
          CFG_EDGE_SMALL:  cfg_edge_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    wmask_r   <= wmask_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    k_r       <= k_nxt;
    cap_r     <= cap_nxt;
    kf_r      <= kf_nxt;
    rem_w_r   <= rem_w_nxt;
    rem_h_r   <= rem_h_nxt;
    mask_r    <= mask_nxt;
    iss_row_r <= iss_row_nxt;
    iss_cnt_r <= iss_cnt_nxt;
    chk_row_r <= chk_row_nxt;
    chk_cnt_r <= chk_cnt_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_ls_r  <= out_ls_nxt;
    out_valid_r <= out_valid_nxt;
    out_last_r  <= out_last_nxt;
    if (ram_re) begin
      rd_vld_r <= row_vld_r[iss_row_r];
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_tile_x        = out_x_r;
  assign out_tile_y        = out_y_r;
  assign out_tile_log_side = out_ls_r;
  assign out_tile_valid    = out_valid_r;
  assign out_last_tile     = out_last_r;

endmodule

>>> hw/rtl/gpsc_chk.sv
// ----------------------------------------------------------------------------
// gpsc_chk - port checker for the square cover block
// Watches request, result and config ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module gpsc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [gpsc_pkg::TILE_XY_W-1:0]  out_tile_x,
  input logic [gpsc_pkg::TILE_XY_W-1:0]  out_tile_y,
  input logic [gpsc_pkg::TILE_LS_W-1:0]  out_tile_log_side,
  input logic                            out_tile_valid,
  input logic                            out_last_tile,
  input logic                            cfg_we
);

  import gpsc_pkg::*;

  // A taken request either starts work or answers at once.
  a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request neither started work nor gave a result");

  // Finishing work always delivers the tile.
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("work ended without a result");

  // Results appear only once the block is free again.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  // An invalid tile carries only zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_tile_valid) |->
      (out_tile_x == '0 && out_tile_y == '0 && out_tile_log_side == '0 &&
       !out_last_tile))
    else $error("invalid tile with non-zero fields");

  // Registers are only written while no request is being worked on.
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !busy)
    else $error("register written while busy");

endmodule

bind greedy_pow2_square_cover gpsc_chk u_gpsc_chk (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the power-of-two square cover block
// Requests are sent through the start/busy port while the grid registers are
// changed between phases. A behavioural model of the cover, kept in step with
// every accepted request, predicts each tile, and a monitor compares every
// strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import gpsc_pkg::*;

  // Geometry of the block as instantiated, and the scan limits of the
  // exponent search.
  localparam int GRID_MAX         = 64;
  localparam int LOG_SIDE_MAX     = 6;
  localparam int SCAN_TOP_LOG     = 29;
  localparam int GROWTH_LIMIT_LOG = 30;

  // An index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // The slowest request scans every row and tests every side up to 64. The
  // limit counts the cycles of the whole run, not those of one request.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [TILE_XY_W-1:0] x;
    logic [TILE_XY_W-1:0] y;
    logic [TILE_LS_W-1:0] log_side;
    logic                 valid;
    logic                 last;
  } tile_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_restart;
  logic                  out_strobe;
  logic [TILE_XY_W-1:0]  out_tile_x;
  logic [TILE_XY_W-1:0]  out_tile_y;
  logic [TILE_LS_W-1:0]  out_tile_log_side;
  logic                  out_tile_valid;
  logic                  out_last_tile;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  greedy_pow2_square_cover dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_restart        (in_restart),
    .out_strobe        (out_strobe),
    .out_tile_x        (out_tile_x),
    .out_tile_y        (out_tile_y),
    .out_tile_log_side (out_tile_log_side),
    .out_tile_valid    (out_tile_valid),
    .out_last_tile     (out_last_tile),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Model of the block. The registers follow every write at once, while the
  // active geometry is only taken from them when a restart request arrives.
  logic [CFG_DATA_W-1:0] reg_width;
  logic [CFG_DATA_W-1:0] reg_height;
  logic                  reg_edge;
  logic [GRID_MAX-1:0]   cover_rows [GRID_MAX];
  int                    cells_left;
  int                    act_w;
  int                    act_h;
  logic                  act_edge;

  // Tiles predicted for accepted requests, oldest first.
  tile_t pending_tiles [$];
  tile_t seen_tile;

  int errors;
  int cycle_count;
  int requests_sent;
  int restarts_sent;
  int results_checked;
  int edge_tiles_checked;

  // --------------------------------------------------------------------------
  // Clock, watchdog and result monitor
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is ended here if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_tiles.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // A result is held for exactly one cycle, so it is taken at the rising edge
  // that ends its strobe cycle; the values read here are those before the edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_tiles.size() == 0) begin
        $display("%0t: result with no request outstanding, got x %0d y %0d log %0d",
                 $time, out_tile_x, out_tile_y, out_tile_log_side);
        errors++;
      end else begin
        seen_tile = pending_tiles.pop_front();
        results_checked++;
        check_field("tile_x", int'(seen_tile.x), int'(out_tile_x));
        check_field("tile_y", int'(seen_tile.y), int'(out_tile_y));
        check_field("tile_log_side", int'(seen_tile.log_side), int'(out_tile_log_side));
        check_field("tile_valid", int'(seen_tile.valid), int'(out_tile_valid));
        check_field("last_tile", int'(seen_tile.last), int'(out_last_tile));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cover model
  // --------------------------------------------------------------------------
  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Bits x0 .. x0+side-1 of a map row.
  function automatic logic [GRID_MAX-1:0] span_mask(input int x0, input int side);
    logic [GRID_MAX-1:0] m;
    m = (side >= GRID_MAX) ? '1 : ((GRID_MAX'(1) << side) - GRID_MAX'(1));
    return m << x0;
  endfunction

  function automatic bit square_clear(input int x0, input int y0, input int side);
    logic [GRID_MAX-1:0] m;
    int r;
    m = span_mask(x0, side);
    for (r = y0; r < y0 + side; r++)
      if ((cover_rows[r] & m) != '0) return 1'b0;
    return 1'b1;
  endfunction

  // In edge mode the largest square that fits at the tile's corner decides the
  // cap: touching the border allows only single cells, one cell away allows
  // at most a 2x2 tile, and further in the exponent of that square is the cap.
  function automatic int edge_cap(input int x0, input int y0);
    int k;
    int side;
    int d;
    for (k = SCAN_TOP_LOG; k >= 0; k--) begin
      side = 1 << k;
      if (x0 + side > act_w || y0 + side > act_h) continue;
      d = min_int(min_int(x0, y0), min_int(act_w - x0 - side, act_h - y0 - side));
      if (d == 0) return 0;
      if (d == 1) return min_int(k, 1);
      return k;
    end
    return 0;
  endfunction

  // Works out the tile for one accepted request and updates the model state.
  function automatic tile_t predict_tile(input logic restart);
    tile_t t;
    int fx;
    int fy;
    int cap;
    int k;
    int sz;
    int r;
    int c;
    int newly;
    bit found;
    logic [GRID_MAX-1:0] m;
    t = '0;
    fx = 0;
    fy = 0;
    found = 1'b0;
    if (restart) begin
      for (r = 0; r < GRID_MAX; r++) cover_rows[r] = '0;
      act_w = (reg_width > GRID_MAX) ? GRID_MAX : int'(reg_width);
      act_h = (reg_height > GRID_MAX) ? GRID_MAX : int'(reg_height);
      act_edge = reg_edge;
      cells_left = act_w * act_h;
    end
    // A finished or empty cover answers with an all-zero invalid result.
    if (cells_left == 0) return t;
    for (r = 0; r < act_h && !found; r++)
      for (c = 0; c < act_w && !found; c++)
        if (!cover_rows[r][c]) begin
          fx = c;
          fy = r;
          found = 1'b1;
        end
    if (!found) begin
      cells_left = 0;
      return t;
    end
    cap = act_edge ? edge_cap(fx, fy) : SCAN_TOP_LOG;
    if (cap > LOG_SIDE_MAX) cap = LOG_SIDE_MAX;
    k = 0;
    while (k + 1 < GROWTH_LIMIT_LOG && k + 1 <= cap) begin
      sz = 1 << (k + 1);
      if (fx + sz > act_w || fy + sz > act_h) break;
      if (!square_clear(fx, fy, sz)) break;
      k++;
    end
    sz = 1 << k;
    m = span_mask(fx, sz);
    for (r = fy; r < fy + sz; r++) begin
      newly = $countones(m & ~cover_rows[r]);
      cells_left = (cells_left > newly) ? cells_left - newly : 0;
      cover_rows[r] = cover_rows[r] | m;
    end
    t.x = fx[TILE_XY_W-1:0];
    t.y = fy[TILE_XY_W-1:0];
    t.log_side = k[TILE_LS_W-1:0];
    t.valid = 1'b1;
    t.last = (cells_left == 0);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Request and register drivers
  // --------------------------------------------------------------------------

  // Sends one request and predicts its tile once it is taken. With a gap of
  // zero, start is left high so that the next request follows at once; the
  // next call or release_start then sets it at the following falling edge.
  task automatic send_request(input logic restart, input int gap);
    tile_t predicted;
    @(negedge clk);
    start = 1'b1;
    in_restart = restart;
    do @(posedge clk); while (busy);
    predicted = predict_tile(restart);
    pending_tiles = {pending_tiles, predicted};
    requests_sent++;
    if (restart) restarts_sent++;
    if (act_edge) edge_tiles_checked++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      // The restart line is noise while start is low and must be ignored.
      in_restart = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_start();
    @(negedge clk);
    start = 1'b0;
    in_restart = 1'b0;
  endtask

  // Registers are only written once every outstanding tile has come back and
  // the block has dropped busy.
  task automatic wait_idle();
    release_start();
    while (pending_tiles.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  reg_width = val;
      CFG_GRID_HEIGHT: reg_height = val;
      CFG_EDGE_SMALL:  reg_edge = val[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int w, input int h, input logic edge_on);
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_EDGE_SMALL, {{(CFG_DATA_W-1){1'b0}}, edge_on});
  endtask

  // Sender idling comes in short bursts, with runs of back-to-back requests.
  function automatic int pick_gap(input bit idling);
    if (!idling) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before any restart the cover counts as complete. The reset geometry of
  // 64 by 64 without the edge rule is then covered by one largest tile.
  task automatic test_after_reset();
    send_request(1'b0, 1);
    send_request(1'b1, 0);
    send_request(1'b0, 2);
    wait_idle();
  endtask

  // Empty grid, saturating size registers with every data bit set, the
  // smallest grid, and a write to an index that holds no register.
  task automatic test_size_extremes();
    set_grid(0, 5, 1'b0);
    send_request(1'b1, 1);
    wait_idle();
    set_grid(127, 127, 1'b0);
    send_request(1'b1, 1);
    wait_idle();
    set_grid(1, 1, 1'b0);
    write_reg(CFG_SPARE_IDX, 7'd100);
    send_request(1'b1, 0);
    send_request(1'b0, 1);
    wait_idle();
  endtask

  // New register values written part way through a cover must not take
  // effect before the next restart request.
  task automatic test_mid_cover_write();
    set_grid(3, 2, 1'b0);
    send_request(1'b1, 1);
    wait_idle();
    set_grid(64, 64, 1'b1);
    send_request(1'b0, 0);
    send_request(1'b0, 0);
    send_request(1'b0, 1);
    wait_idle();
  endtask

  // A 4 by 4 grid in edge mode: single cells along the border and a 2x2
  // tile one cell in from it.
  task automatic test_edge_cap();
    int n;
    set_grid(4, 4, 1'b1);
    send_request(1'b1, 0);
    n = 0;
    while (cells_left > 0 && n < 20) begin
      send_request(1'b0, pick_gap(1'b1));
      n++;
    end
    wait_idle();
  endtask

  // Chooses a random grid shape: mostly small grids, sometimes empty or
  // oversized ones, and long strips that reach the far rows and columns.
  task automatic pick_random_grid();
    int shape;
    shape = $urandom_range(0, 11);
    case (shape)
      0: begin
        if ($urandom_range(0, 1))
          set_grid(0, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
        else
          set_grid($urandom_range(0, 127), 0, 1'($urandom_range(0, 1)));
      end
      1: set_grid($urandom_range(33, 127), $urandom_range(33, 127), 1'b0);
      2: set_grid($urandom_range(48, 127), $urandom_range(1, 2),
                  1'($urandom_range(0, 1)));
      3: set_grid($urandom_range(1, 2), $urandom_range(48, 127),
                  1'($urandom_range(0, 1)));
      default: set_grid($urandom_range(1, 12), $urandom_range(1, 12),
                        1'($urandom_range(0, 1)));
    endcase
  endtask

  // Whole covers with random geometry. Most requests ask for the next tile
  // until the cover is done; a few restart part way through or come after
  // the end, and now and then a register changes in the middle of a cover.
  task automatic test_random_covers(input int n_items, input bit idling);
    int done_items;
    int roll;
    int extra;
    done_items = 0;
    while (done_items < n_items) begin
      wait_idle();
      pick_random_grid();
      send_request(1'b1, pick_gap(idling));
      done_items++;
      while (cells_left > 0 && done_items < n_items) begin
        roll = $urandom_range(0, 99);
        if (roll >= 4 && roll < 7) begin
          wait_idle();
          write_reg(CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 127)));
        end
        send_request(roll < 4, pick_gap(idling));
        done_items++;
      end
      extra = $urandom_range(0, 2);
      while (extra > 0 && done_items < n_items) begin
        send_request(1'b0, pick_gap(idling));
        done_items++;
        extra--;
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_wdata = '0;
    errors = 0;
    cycle_count = 0;
    requests_sent = 0;
    restarts_sent = 0;
    results_checked = 0;
    edge_tiles_checked = 0;
    reg_width = GRID_DIM_RST;
    reg_height = GRID_DIM_RST;
    reg_edge = 1'b0;
    for (int r = 0; r < GRID_MAX; r++) cover_rows[r] = '0;
    cells_left = 0;
    act_w = 0;
    act_h = 0;
    act_edge = 1'b0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_size_extremes();
    test_mid_cover_write();
    test_edge_cap();
    test_random_covers(340, 1'b1);
    // The closing stretch runs with the sender never idle.
    test_random_covers(60, 1'b0);

    release_start();
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, %0d of them restarts; checked %0d results.",
             requests_sent, restarts_sent, results_checked);
    $display("Requests served in edge mode: %0d; errors found: %0d.",
             edge_tiles_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
